@@ hw/rtl/ptsch_pkg.sv @@
// Shared types and constants for the priority thread scheduler.
// Holds the item kind codes and the controller/datapath command and status bundles.
// No dependencies.
package ptsch_pkg;

	typedef enum logic [2:0] {
		KIND_TICK   = 3'd0,
		KIND_SCHED  = 3'd1,
		KIND_SLEEP  = 3'd2,
		KIND_WAIT   = 3'd3,
		KIND_SIGNAL = 3'd4,
		KIND_SET    = 3'd5
	} kind_t;

	localparam int unsigned MS_PER_S    = 1000;
	localparam int unsigned TICKS_PER_S = 100;
	localparam logic [15:0] TICK_STEP_RST = 16'(MS_PER_S / TICKS_PER_S);
	localparam logic [7:0]  PRIO_NONE     = 8'd255;

	localparam int unsigned SDATA_W = 32;
	localparam int unsigned MDATA_W = 16;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic wake;
		logic load_out;
	} ptsch_cmd_t;

	typedef struct packed {
		logic need_sched;
		logic need_wake;
		logic last;
		logic wake_done;
	} ptsch_stat_t;

endpackage

@@ hw/rtl/priority_thread_scheduler.sv @@
// Each input beat goes through capture, execution and result load. Schedule, sleep and a
// blocking wait add a scan of all NUM_THREADS ring slots; a signal that must wake a thread
// adds a ring search that stops at the first match. The next beat is taken as the result
// appears; a stalled result does not hold it back, but its own result waits for the slot.
// Reset (arst_n low, asynchronous) clears thread state, semaphores, the running thread and
// the idle flag, and loads priorities 0 and a tick step of 10. Ties ptsch_ctrl and ptsch_dp.
module priority_thread_scheduler import ptsch_pkg::*; #(
	parameter int NUM_THREADS = 8,
	parameter int NUM_SEMS    = 4,
	parameter int SLEEP_BITS  = 16,
	parameter int COUNT_BITS  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [SDATA_W-1:0] s_tdata,  // sem_id[1:0], sleep_ms[17:2], sem_init[25:18], zero
	input  logic [2:0]         s_tuser,  // kind[2:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [MDATA_W-1:0] m_tdata   // running_thread[2:0], none_ready[3], sem_count[11:4], zero
);

	ptsch_cmd_t        cmd;
	ptsch_stat_t       stat;
	logic [2:0]        out_running;
	logic              out_none_ready;
	logic signed [7:0] out_sem_count;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {4'd0, out_sem_count, out_none_ready, out_running};

	ptsch_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ptsch_dp #(
		.NUM_THREADS (NUM_THREADS),
		.NUM_SEMS    (NUM_SEMS),
		.SLEEP_BITS  (SLEEP_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_sel        (cfg_index[0]),
		.cfg_wdata      (cfg_data),
		.in_kind        (s_tuser),
		.in_sem_id      (s_tdata[1:0]),
		.in_sleep_ms    (s_tdata[17:2]),
		.in_sem_init    (s_tdata[25:18]),
		.cmd            (cmd),
		.stat           (stat),
		.out_running    (out_running),
		.out_none_ready (out_none_ready),
		.out_sem_count  (out_sem_count)
	);

endmodule

@@ hw/rtl/ptsch_ctrl.sv @@
// Controller state machine of the priority thread scheduler.
// Sequences capture, execution, the ring scans and result hand-over; uses ptsch_pkg.
module ptsch_ctrl import ptsch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  ptsch_stat_t stat,
	output ptsch_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_WAKE,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.wake     = (state_q == ST_WAKE);
		cmd.load_out = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (stat.need_sched)
						state_q <= ST_SCAN;
					else if (stat.need_wake)
						state_q <= ST_WAKE;
					else
						state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (stat.last)
						state_q <= ST_DONE;
				end
				ST_WAKE: begin
					if (stat.wake_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/ptsch_dp.sv @@
// Datapath of the priority thread scheduler: thread table, semaphores and ring cursor.
// Acts on commands from ptsch_ctrl; uses ptsch_pkg.
module ptsch_dp import ptsch_pkg::*; #(
	parameter int NUM_THREADS = 8,
	parameter int NUM_SEMS    = 4,
	parameter int SLEEP_BITS  = 16,
	parameter int COUNT_BITS  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_sel,
	input  logic [63:0]        cfg_wdata,
	input  logic [2:0]         in_kind,
	input  logic [1:0]         in_sem_id,
	input  logic [15:0]        in_sleep_ms,
	input  logic signed [7:0]  in_sem_init,
	input  ptsch_cmd_t         cmd,
	output ptsch_stat_t        stat,
	output logic [2:0]         out_running,
	output logic               out_none_ready,
	output logic signed [7:0]  out_sem_count
);

	localparam int TW = $clog2(NUM_THREADS);
	localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam logic [TW-1:0] LAST_T = TW'(NUM_THREADS - 1);
	localparam logic signed [33:0] CMAX = (34'sd1 <<< (COUNT_BITS - 1)) - 34'sd1;
	localparam logic signed [33:0] CMIN = -(34'sd1 <<< (COUNT_BITS - 1));
	localparam logic signed [33:0] SMAX = (34'sd1 <<< SLEEP_BITS) - 34'sd1;

	logic [63:0]            prio_q;
	logic [15:0]            step_q;
	logic [TW-1:0]          run_q;
	logic                   idle_q;
	logic [SLEEP_BITS-1:0]  sleep_q [NUM_THREADS];
	logic                   blk_q   [NUM_THREADS];
	logic [1:0]             bon_q   [NUM_THREADS];
	logic signed [COUNT_BITS-1:0] sem_q [NUM_SEMS];

	kind_t                  kind_q;
	logic [1:0]             sid_q;
	logic [15:0]            ms_q;
	logic signed [7:0]      init_q;

	logic [TW-1:0]          cur_q;
	logic [TW-1:0]          cnt_q;
	logic [TW-1:0]          pick_q;
	logic [7:0]             best_q;
	logic                   found_q;

	logic                   sem_ok;
	logic [SW-1:0]          sidx;
	logic signed [COUNT_BITS-1:0] sem_cur, sem_dec, sem_inc, sem_set;
	logic signed [33:0]     w_dec, w_inc, w_set, w_cur, w_ms;
	logic [SLEEP_BITS-1:0]  ms_sat;
	logic [TW-1:0]          cur_nxt, run_nxt;
	logic [7:0]             prio_cur;
	logic                   rdy_cur, scan_hit, wake_hit, last;
	logic signed [7:0]      sem_out;

	assign sem_ok  = 32'(sid_q) < 32'(NUM_SEMS);
	assign sidx    = SW'(sid_q);
	assign sem_cur = sem_ok ? sem_q[sidx] : '0;

	assign w_cur = 34'(sem_cur);
	assign w_dec = w_cur - 34'sd1;
	assign w_inc = w_cur + 34'sd1;
	assign w_set = 34'(init_q);
	assign w_ms  = $signed({18'd0, ms_q});

	always_comb begin
		sem_dec = (w_dec < CMIN) ? COUNT_BITS'(CMIN) : COUNT_BITS'(w_dec);
		sem_inc = (w_inc > CMAX) ? COUNT_BITS'(CMAX) : COUNT_BITS'(w_inc);
		if (w_set > CMAX)
			sem_set = COUNT_BITS'(CMAX);
		else if (w_set < CMIN)
			sem_set = COUNT_BITS'(CMIN);
		else
			sem_set = COUNT_BITS'(w_set);
		ms_sat = (w_ms > SMAX) ? SLEEP_BITS'(SMAX) : SLEEP_BITS'(w_ms);
		// The result field is eight bits wide whatever the count width is.
		if (w_cur > 34'sd127)
			sem_out = 8'sd127;
		else if (w_cur < -34'sd128)
			sem_out = -8'sd128;
		else
			sem_out = 8'(w_cur);
	end

	assign cur_nxt = (cur_q == LAST_T) ? '0 : cur_q + 1'b1;
	assign run_nxt = (run_q == LAST_T) ? '0 : run_q + 1'b1;
	// Threads beyond the eighth have no priority field and are never chosen.
	assign prio_cur = (32'(cur_q) < 32'd8) ? prio_q[{3'(cur_q), 3'b000} +: 8] : PRIO_NONE;
	assign rdy_cur  = !blk_q[cur_q] && (sleep_q[cur_q] == '0);
	assign scan_hit = rdy_cur && (prio_cur < best_q);
	assign wake_hit = blk_q[cur_q] && (bon_q[cur_q] == sid_q);
	assign last     = (cnt_q == LAST_T);

	always_comb begin
		stat            = '0;
		stat.need_sched = (kind_q == KIND_SCHED) || (kind_q == KIND_SLEEP) ||
		                  ((kind_q == KIND_WAIT) && sem_ok && (sem_dec < 0));
		stat.need_wake  = (kind_q == KIND_SIGNAL) && sem_ok && (sem_inc <= 0);
		stat.last       = last;
		stat.wake_done  = wake_hit || last;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind_t'(in_kind);
			sid_q  <= in_sem_id;
			ms_q   <= in_sleep_ms;
			init_q <= in_sem_init;
		end
		if (cmd.exec) begin
			cur_q   <= run_nxt;
			cnt_q   <= '0;
			pick_q  <= run_q;
			best_q  <= PRIO_NONE;
			found_q <= 1'b0;
		end
		if (cmd.scan || cmd.wake) begin
			cur_q <= cur_nxt;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.scan && scan_hit) begin
			best_q  <= prio_cur;
			pick_q  <= cur_q;
			found_q <= 1'b1;
		end
		if (cmd.load_out) begin
			out_running    <= 3'(run_q);
			out_none_ready <= idle_q;
			out_sem_count  <= sem_ok ? sem_out : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q <= '0;
			step_q <= TICK_STEP_RST;
			run_q  <= '0;
			idle_q <= 1'b0;
			for (int i = 0; i < NUM_THREADS; i++) begin
				sleep_q[i] <= '0;
				blk_q[i]   <= 1'b0;
				bon_q[i]   <= '0;
			end
			for (int i = 0; i < NUM_SEMS; i++)
				sem_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_sel)
					step_q <= cfg_wdata[15:0];
				else
					prio_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				case (kind_q)
					KIND_TICK: begin
						for (int i = 0; i < NUM_THREADS; i++)
							sleep_q[i] <= ({16'd0, sleep_q[i]} > {SLEEP_BITS'(0), step_q})
								? SLEEP_BITS'({16'd0, sleep_q[i]} - {SLEEP_BITS'(0), step_q})
								: '0;
					end
					KIND_SLEEP: sleep_q[run_q] <= ms_sat;
					KIND_WAIT: begin
						if (sem_ok) begin
							sem_q[sidx] <= sem_dec;
							if (sem_dec < 0) begin
								blk_q[run_q] <= 1'b1;
								bon_q[run_q] <= sid_q;
							end
						end
					end
					KIND_SIGNAL: begin
						if (sem_ok)
							sem_q[sidx] <= sem_inc;
					end
					KIND_SET: begin
						if (sem_ok)
							sem_q[sidx] <= sem_set;
					end
					default: ;
				endcase
			end
			// The last scan beat commits the choice, counting this beat's candidate too.
			if (cmd.scan && last) begin
				if (found_q || scan_hit) begin
					run_q  <= scan_hit ? cur_q : pick_q;
					idle_q <= 1'b0;
				end else begin
					idle_q <= 1'b1;
				end
			end
			if (cmd.wake && wake_hit) begin
				blk_q[cur_q] <= 1'b0;
				bon_q[cur_q] <= '0;
			end
		end
	end

endmodule

@@ hw/rtl/ptsch_checker.sv @@
// Port-level checks for the priority thread scheduler, bound to the top level.
// Depends on priority_thread_scheduler only through its ports.
module ptsch_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second input beat taken while an item is in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared before execution finished");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:12] == 4'd0)
		else $error("padding bits of result beat not zero");

endmodule

bind priority_thread_scheduler ptsch_checker u_ptsch_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ dv/tb_priority_thread_scheduler.sv @@
// Self-checking testbench for the priority thread scheduler: stream driver, result monitor,
// and a behavioural predictor of threads and semaphores. Depends on ptsch_pkg and the top level.
module tb_priority_thread_scheduler;
	import ptsch_pkg::*;

	localparam int NTHR = 8;
	localparam int NSEM = 4;
	localparam int WDOG_LIMIT = 4000;
	localparam logic [0:0] REG_PRIO = 1'b0;
	localparam logic [0:0] REG_STEP = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  sem_id;
		logic [15:0] sleep_ms;
		logic [7:0]  sem_init;
	} op_t;

	typedef struct packed {
		logic [2:0] thread;
		logic       idle;
		logic [7:0] count;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	op_t     pending_ops[$];
	status_t expected_status[$];
	int      errors = 0;
	int      idle_cycles = 0;
	int      send_gap = 0;
	int      recv_gap = 0;
	bit      hold_sender = 1'b1;

	// Predictor state.
	logic [63:0] prio_reg;
	logic [15:0] step_reg;
	logic [2:0]  cur_thread;
	logic [15:0] sleep_left[NTHR];
	logic        blocked[NTHR];
	logic [1:0]  blocked_sem[NTHR];
	int          sem_cnt[NSEM];
	logic        idle_state;

	priority_thread_scheduler dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int sat8(int v);
		if (v > 127) return 127;
		if (v < -128) return -128;
		return v;
	endfunction

	function automatic void pick_thread();
		int best;
		int t;
		bit found;
		best = 255;
		t = int'(cur_thread);
		found = 1'b0;
		for (int n = 0; n < NTHR; n++) begin
			t = (t + 1) % NTHR;
			if (!blocked[t] && sleep_left[t] == 0 && int'(prio_reg[8*t +: 8]) < best) begin
				best = int'(prio_reg[8*t +: 8]);
				cur_thread = 3'(t);
				found = 1'b1;
			end
		end
		idle_state = !found;
	endfunction

	function automatic status_t apply_op(op_t op);
		status_t r;
		int t;
		int s;
		s = int'(op.sem_id);
		case (op.kind)
			KIND_TICK: begin
				for (int i = 0; i < NTHR; i++)
					sleep_left[i] = (sleep_left[i] > step_reg) ? sleep_left[i] - step_reg : '0;
			end
			KIND_SCHED: pick_thread();
			KIND_SLEEP: begin
				sleep_left[cur_thread] = op.sleep_ms;
				pick_thread();
			end
			KIND_WAIT: begin
				sem_cnt[s] = sat8(sem_cnt[s] - 1);
				if (sem_cnt[s] < 0) begin
					blocked[cur_thread] = 1'b1;
					blocked_sem[cur_thread] = op.sem_id;
					pick_thread();
				end
			end
			KIND_SIGNAL: begin
				sem_cnt[s] = sat8(sem_cnt[s] + 1);
				if (sem_cnt[s] <= 0) begin
					t = int'(cur_thread);
					for (int n = 0; n < NTHR; n++) begin
						t = (t + 1) % NTHR;
						if (blocked[t] && blocked_sem[t] == op.sem_id) begin
							blocked[t] = 1'b0;
							blocked_sem[t] = '0;
							break;
						end
					end
				end
			end
			KIND_SET: sem_cnt[s] = int'($signed(op.sem_init));
			default: ;
		endcase
		r.thread = cur_thread;
		r.idle = idle_state;
		r.count = 8'(sem_cnt[s]);
		return r;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("error: %s got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// Driver: one beat per pending item, random gap before each.
	always @(posedge clk) begin
		int gap;
		if (s_tvalid && s_tready) begin
			expected_status.push_back(apply_op(pending_ops.pop_front()));
			gap = $urandom_range(0, 8);
			if (gap == 0 && !hold_sender && pending_ops.size() > 0) begin
				send_gap <= 0;
				s_tuser <= pending_ops[0].kind;
				s_tdata <= {6'd0, pending_ops[0].sem_init, pending_ops[0].sleep_ms,
					pending_ops[0].sem_id};
			end else begin
				send_gap <= gap;
				s_tvalid <= 1'b0;
			end
		end else if (!s_tvalid && !hold_sender && pending_ops.size() > 0) begin
			if (send_gap > 1) begin
				send_gap <= send_gap - 1;
			end else begin
				send_gap <= 0;
				s_tvalid <= 1'b1;
				s_tuser <= pending_ops[0].kind;
				s_tdata <= {6'd0, pending_ops[0].sem_init, pending_ops[0].sleep_ms,
					pending_ops[0].sem_id};
			end
		end
	end

	// Monitor: random back-pressure, compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		status_t want;
		int gap;
		if (m_tvalid && m_tready) begin
			if (expected_status.size() == 0) begin
				report("unexpected result", m_tdata, '0);
			end else begin
				want = expected_status.pop_front();
				if (m_tdata[2:0] !== want.thread)
					report("running_thread", 16'(m_tdata[2:0]), 16'(want.thread));
				if (m_tdata[3] !== want.idle)
					report("none_ready", 16'(m_tdata[3]), 16'(want.idle));
				if (m_tdata[11:4] !== want.count)
					report("sem_count", 16'(m_tdata[11:4]), 16'(want.count));
				if (m_tdata[15:12] !== '0)
					report("padding", 16'(m_tdata[15:12]), '0);
			end
			gap = $urandom_range(0, 8);
			recv_gap <= gap;
			m_tready <= (gap == 0);
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= (recv_gap == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no accepted beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_LIMIT) begin
			$display("priority_thread_scheduler: mismatch");
			$finish;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_PRIO) prio_reg = value;
		else step_reg = value[15:0];
	endtask

	task automatic drain();
		hold_sender = 1'b0;
		wait (pending_ops.size() == 0 && !s_tvalid);
		wait (expected_status.size() == 0);
		hold_sender = 1'b1;
		repeat (20) @(posedge clk);
	endtask

	function automatic op_t make_op(logic [2:0] k, logic [1:0] s, logic [15:0] ms,
			logic [7:0] init);
		op_t o;
		o.kind = k;
		o.sem_id = s;
		o.sleep_ms = ms;
		o.sem_init = init;
		return o;
	endfunction

	// Biased towards the ranges where sleeps expire and semaphores block and wake.
	function automatic op_t random_op();
		op_t o;
		int pick;
		pick = $urandom_range(0, 99);
		o = make_op(3'($urandom_range(0, 5)), 2'($urandom), 16'($urandom_range(0, 60)),
			8'($urandom));
		if (pick < 4) o.kind = 3'(6 + $urandom_range(0, 1));
		if (pick < 10) o.sleep_ms = 16'($urandom);
		if (o.kind == KIND_SET && pick < 70) o.sem_init = 8'($urandom_range(0, 3) - 2);
		return o;
	endfunction

	initial begin
		logic [63:0] prio_sets[4];
		logic [15:0] step_sets[4];
		prio_reg = '0;
		step_reg = TICK_STEP_RST;
		cur_thread = '0;
		idle_state = 1'b0;
		for (int i = 0; i < NTHR; i++) begin
			sleep_left[i] = '0;
			blocked[i] = 1'b0;
			blocked_sem[i] = '0;
		end
		for (int i = 0; i < NSEM; i++) sem_cnt[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset values first, then extremes, blocking, waking and idle.
		pending_ops.push_back(make_op(KIND_SCHED, 2'd0, 16'd0, 8'd0));
		pending_ops.push_back(make_op(KIND_SET, 2'd3, 16'hffff, 8'h7f));
		pending_ops.push_back(make_op(KIND_SIGNAL, 2'd3, 16'd0, 8'd0));
		pending_ops.push_back(make_op(KIND_SET, 2'd2, 16'd0, 8'h80));
		pending_ops.push_back(make_op(KIND_WAIT, 2'd2, 16'd0, 8'd0));
		pending_ops.push_back(make_op(KIND_SET, 2'd1, 16'd0, 8'h00));
		pending_ops.push_back(make_op(KIND_WAIT, 2'd1, 16'd0, 8'd0));
		pending_ops.push_back(make_op(KIND_WAIT, 2'd1, 16'd0, 8'd0));
		pending_ops.push_back(make_op(KIND_SIGNAL, 2'd1, 16'd0, 8'd0));
		pending_ops.push_back(make_op(KIND_SLEEP, 2'd0, 16'hffff, 8'd0));
		pending_ops.push_back(make_op(KIND_TICK, 2'd0, 16'd0, 8'd0));
		pending_ops.push_back(make_op(3'd6, 2'd1, 16'd0, 8'd0));
		pending_ops.push_back(make_op(3'd7, 2'd2, 16'd0, 8'd0));
		for (int i = 0; i < NTHR; i++)
			pending_ops.push_back(make_op(KIND_SLEEP, 2'd0, 16'd5, 8'd0));
		pending_ops.push_back(make_op(KIND_SCHED, 2'd0, 16'd0, 8'd0));
		pending_ops.push_back(make_op(KIND_TICK, 2'd0, 16'd0, 8'd0));
		pending_ops.push_back(make_op(KIND_SCHED, 2'd0, 16'd0, 8'd0));
		drain();

		prio_sets[0] = 64'hffff_ffff_ffff_ffff;
		prio_sets[1] = 64'h0;
		prio_sets[2] = 64'h0102_0304_0102_0304;
		prio_sets[3] = {$urandom, $urandom};
		step_sets[0] = 16'hffff;
		step_sets[1] = 16'd0;
		step_sets[2] = 16'd7;
		step_sets[3] = 16'($urandom);
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_PRIO, prio_sets[ph]);
			write_reg(REG_STEP, step_sets[ph]);
			for (int n = 0; n < 200; n++) pending_ops.push_back(random_op());
			drain();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && expected_status.size() == 0)
			$display("priority_thread_scheduler: match");
		else
			$display("priority_thread_scheduler: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/ptsch_pkg.sv
hw/rtl/ptsch_ctrl.sv
hw/rtl/ptsch_dp.sv
hw/rtl/priority_thread_scheduler.sv
hw/rtl/ptsch_checker.sv
dv/tb_priority_thread_scheduler.sv
